### design/tcfr_pkg.sv
// tcfr_pkg: shared types and constants of the two color frame receiver
// command word passed from the front classifier to the back executor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcfr_pkg;

  localparam logic [7:0] ChStart = 8'h53;
  localparam logic [7:0] ChEnd   = 8'h45;

  localparam logic [1:0] ModeIdle = 2'd0;
  localparam logic [1:0] ModeRed  = 2'd1;
  localparam logic [1:0] ModeBlue = 2'd2;
  localparam logic [1:0] ModeWait = 2'd3;

  // command queue depth and pointer width
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;

  typedef enum logic [1:0] {
    KindStatus = 2'd0,
    KindReply  = 2'd1,
    KindFrame  = 2'd2
  } kind_e;

  // one classified byte: optional store write, then a single result or a commit
  typedef struct packed {
    logic       commit;
    logic       wr;
    logic       wr_color;
    logic [7:0] addr;
    logic [7:0] wr_data;
    kind_e      kind;
    logic [7:0] data;
    logic [1:0] mode;
  } cmd_t;

endpackage

`default_nettype wire

### design/two_color_frame_receiver.sv
// two color frame receiver: a request is taken in any cycle the command queue has room;
// its single result is loaded into the output register once the back end pops it from the queue
// a commit's frame bytes are read from the stores into a staging register, then leave one per cycle
// while the output is taken, for 2*FRAME_BYTES bytes; the back end pops no command during a commit
// reset clears the phase, fill count, queue and output valid; stores hold garbage until filled
`timescale 1ns / 1ps
`default_nettype none

module two_color_frame_receiver
  import tcfr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 24
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_o,
  output logic            color_o,
  output logic [4:0]      position_o,
  output logic [1:0]      mode_o,
  output logic            last_o
);

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;

  assign in_ready_o = !q_full;
  assign push       = in_valid_i && in_ready_o;

  tcfr_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .rx_byte_i (rx_byte_i),
    .cmd_o     (front_cmd)
  );

  tcfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_cmd),
    .pop_i   (pop),
    .rdata_o (back_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tcfr_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .data_o      (data_o),
    .color_o     (color_o),
    .position_o  (position_o),
    .mode_o      (mode_o),
    .last_o      (last_o)
  );

  // frame bytes always report idle mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindFrame |-> mode_o == ModeIdle)
    else $error("frame byte with non-idle mode");

  // single results close their request at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KindFrame |-> last_o)
    else $error("single result without last");

  // only the final blue byte of a commit ends it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindFrame && last_o |-> color_o)
    else $error("commit ended on a red byte");

  // never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("pop from empty command queue");

endmodule

`default_nettype wire

### design/tcfr_queue.sv
// tcfr_queue: small command fifo between front and back
// depends on tcfr_pkg for cmd_t and queue depth
`timescale 1ns / 1ps
`default_nettype none

module tcfr_queue
  import tcfr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t wdata_i,
  input  wire logic pop_i,
  output cmd_t      rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  cmd_t             qmem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   count_q, count_d;

  assign full_o  = (count_q == (QPtrW + 1)'(QDepth));
  assign empty_o = (count_q == '0);
  assign rdata_o = qmem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      qmem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### design/tcfr_front.sv
// tcfr_front: handshake phase machine, classifies each received byte into a command
// depends on tcfr_pkg for cmd_t, modes and characters
`timescale 1ns / 1ps
`default_nettype none

module tcfr_front
  import tcfr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 24
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic [7:0] rx_byte_i,
  output cmd_t            cmd_o
);

  localparam int unsigned AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [AW-1:0] LastPos = AW'(FRAME_BYTES - 1);

  typedef enum logic [3:0] {
    PhIdle = 4'b0001,
    PhRed  = 4'b0010,
    PhBlue = 4'b0100,
    PhWait = 4'b1000
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [AW-1:0] fill_q, fill_d;

  always_comb begin
    phase_d       = phase_q;
    fill_d        = fill_q;
    cmd_o         = '0;
    cmd_o.addr    = 8'(fill_q);
    cmd_o.wr_data = rx_byte_i;
    cmd_o.kind    = KindStatus;
    unique case (phase_q)
      PhIdle: begin
        cmd_o.mode = ModeIdle;
        if (rx_byte_i == ChStart) begin
          phase_d    = PhRed;
          cmd_o.kind = KindReply;
          cmd_o.data = ChStart;
          cmd_o.mode = ModeRed;
        end
      end
      PhRed: begin
        cmd_o.wr       = 1'b1;
        cmd_o.wr_color = 1'b0;
        cmd_o.mode     = ModeRed;
        fill_d         = fill_q + 1'b1;
        if (fill_q == LastPos) begin
          fill_d     = '0;
          phase_d    = PhBlue;
          cmd_o.mode = ModeBlue;
        end
      end
      PhBlue: begin
        cmd_o.wr       = 1'b1;
        cmd_o.wr_color = 1'b1;
        cmd_o.mode     = ModeBlue;
        fill_d         = fill_q + 1'b1;
        if (fill_q == LastPos) begin
          fill_d     = '0;
          phase_d    = PhWait;
          cmd_o.kind = KindReply;
          cmd_o.data = ChEnd;
          cmd_o.mode = ModeWait;
        end
      end
      PhWait: begin
        cmd_o.mode = ModeWait;
        if (rx_byte_i == ChEnd) begin
          phase_d      = PhIdle;
          cmd_o.commit = 1'b1;
          cmd_o.mode   = ModeIdle;
        end
      end
      default: begin
        phase_d = PhIdle;
        fill_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      fill_q  <= '0;
    end else if (push_i) begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
    end
  end

endmodule

`default_nettype wire

### design/tcfr_back.sv
// tcfr_back: executes commands, owns the red and blue stores and the output register
// depends on tcfr_pkg for cmd_t, kinds and modes
`timescale 1ns / 1ps
`default_nettype none

module tcfr_back
  import tcfr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 24
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       cmd_i,
  input  wire logic       q_empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_o,
  output logic            color_o,
  output logic [4:0]      position_o,
  output logic [1:0]      mode_o,
  output logic            last_o
);

  localparam int unsigned AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [AW-1:0] LastPos = AW'(FRAME_BYTES - 1);

  typedef enum logic [1:0] {
    BkIdle   = 2'b01,
    BkStream = 2'b10
  } bk_state_e;

  bk_state_e     state_q, state_d;
  logic [7:0]    red_mem  [FRAME_BYTES];
  logic [7:0]    blue_mem [FRAME_BYTES];
  logic [7:0]    red_rd_q, blue_rd_q;

  logic [AW-1:0] iss_pos_q, iss_pos_d;
  logic          iss_color_q, iss_color_d;
  logic          iss_done_q, iss_done_d;
  logic          p_valid_q, p_valid_d;
  logic [AW-1:0] p_pos_q;
  logic          p_color_q;

  logic          out_valid_q, out_valid_d;
  kind_e         kind_q, kind_d;
  logic [7:0]    data_q, data_d;
  logic          color_q, color_d;
  logic [7:0]    pos_q, pos_d;
  logic [1:0]    mode_q, mode_d;
  logic          last_q, last_d;

  logic          out_free;
  logic          issue;
  logic          move;
  logic          load;
  logic          wr_en;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    iss_pos_d   = iss_pos_q;
    iss_color_d = iss_color_q;
    iss_done_d  = iss_done_q;
    p_valid_d   = p_valid_q;
    pop_o       = 1'b0;
    issue       = 1'b0;
    move        = 1'b0;
    load        = 1'b0;
    wr_en       = 1'b0;
    kind_d      = kind_q;
    data_d      = data_q;
    color_d     = color_q;
    pos_d       = pos_q;
    mode_d      = mode_q;
    last_d      = last_q;
    unique case (state_q)
      BkIdle: begin
        if (!q_empty_i && out_free) begin
          pop_o = 1'b1;
          if (cmd_i.commit) begin
            state_d     = BkStream;
            iss_pos_d   = '0;
            iss_color_d = 1'b0;
            iss_done_d  = 1'b0;
            p_valid_d   = 1'b0;
          end else begin
            wr_en   = cmd_i.wr;
            load    = 1'b1;
            kind_d  = cmd_i.kind;
            data_d  = cmd_i.data;
            color_d = 1'b0;
            pos_d   = '0;
            mode_d  = cmd_i.mode;
            last_d  = 1'b1;
          end
        end
      end
      BkStream: begin
        move  = p_valid_q && out_free;
        issue = !iss_done_q && (!p_valid_q || out_free);
        if (move) begin
          load    = 1'b1;
          kind_d  = KindFrame;
          data_d  = p_color_q ? blue_rd_q : red_rd_q;
          color_d = p_color_q;
          pos_d   = 8'(p_pos_q);
          mode_d  = ModeIdle;
          last_d  = p_color_q && (p_pos_q == LastPos);
        end
        if (issue) begin
          p_valid_d = 1'b1;
          iss_pos_d = iss_pos_q + 1'b1;
          if (iss_pos_q == LastPos) begin
            iss_pos_d = '0;
            if (iss_color_q) begin
              iss_done_d = 1'b1;
            end else begin
              iss_color_d = 1'b1;
            end
          end
        end else if (move) begin
          p_valid_d = 1'b0;
        end
        // all reads issued and the staged byte is gone
        if (iss_done_q && !p_valid_d) begin
          state_d = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      iss_pos_q   <= '0;
      iss_color_q <= 1'b0;
      iss_done_q  <= 1'b0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_pos_q   <= iss_pos_d;
      iss_color_q <= iss_color_d;
      iss_done_q  <= iss_done_d;
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // stores and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en && !cmd_i.wr_color) begin
      red_mem[cmd_i.addr[AW-1:0]] <= cmd_i.wr_data;
    end
    if (wr_en && cmd_i.wr_color) begin
      blue_mem[cmd_i.addr[AW-1:0]] <= cmd_i.wr_data;
    end
    if (issue) begin
      red_rd_q  <= red_mem[iss_pos_q];
      blue_rd_q <= blue_mem[iss_pos_q];
      p_pos_q   <= iss_pos_q;
      p_color_q <= iss_color_q;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    data_q  <= data_d;
    color_q <= color_d;
    pos_q   <= pos_d;
    mode_q  <= mode_d;
    last_q  <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign data_o      = data_q;
  assign color_o     = color_q;
  assign position_o  = pos_q[4:0];
  assign mode_o      = mode_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### test/testbench.sv
// testbench for two_color_frame_receiver: drives serial bytes, tracks the red/blue
// handshake in a local tracker and checks every reply, status and frame byte
// depends on tcfr_pkg and the two_color_frame_receiver rtl
`timescale 1ns / 1ps

module testbench;
  import tcfr_pkg::*;

  localparam int unsigned FrameBytes = 24;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned HoldAt     = 75;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned PhaseItems = 45;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       color;
    logic [4:0] position;
    logic [1:0] mode;
    logic       last;
  } frame_result_t;

  typedef struct {
    logic [7:0]    first;
    logic [7:0]    step;
    int            count;
    bit            typed;
    frame_result_t res;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] data_o;
  logic       color_o;
  logic [4:0] position_o;
  logic [1:0] mode_o;
  logic       last_o;

  two_color_frame_receiver #(
    .FRAME_BYTES(FrameBytes)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .kind_o     (kind_o),
    .data_o     (data_o),
    .color_o    (color_o),
    .position_o (position_o),
    .mode_o     (mode_o),
    .last_o     (last_o)
  );

  // local copy of the receiver state
  logic [1:0]    rx_phase = ModeIdle;
  int unsigned   fill_idx = 0;
  logic [7:0]    red_plane [FrameBytes];
  logic [7:0]    blue_plane[FrameBytes];

  frame_result_t owed_results[$];
  int unsigned   owed_total = 0;
  int unsigned   seen_total = 0;
  int unsigned   taken      = 0;
  int unsigned   err_count  = 0;
  int unsigned   cycles     = 0;
  int unsigned   send_gap_pct = 0;
  int unsigned   recv_gap_pct = 0;
  int unsigned   stall_left = 0;
  bit            stall_done = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic frame_result_t single(kind_e k, logic [7:0] d, logic [1:0] m);
    frame_result_t r;
    r.kind     = k;
    r.data     = d;
    r.color    = 1'b0;
    r.position = 5'd0;
    r.mode     = m;
    r.last     = 1'b1;
    return r;
  endfunction

  // advance the local state by one byte and queue what the block owes for it
  task automatic track_rx_byte(input logic [7:0] b, input bit typed,
                               input frame_result_t typed_res);
    frame_result_t r;
    frame_result_t batch[$];
    bit            commit;
    r      = single(KindStatus, 8'h00, ModeIdle);
    commit = 1'b0;
    case (rx_phase)
      ModeIdle: begin
        if (b == ChStart) begin
          rx_phase = ModeRed;
          r.kind   = KindReply;
          r.data   = ChStart;
        end
      end
      ModeRed: begin
        red_plane[fill_idx] = b;
        fill_idx++;
        if (fill_idx == FrameBytes) begin
          fill_idx = 0;
          rx_phase = ModeBlue;
        end
      end
      ModeBlue: begin
        blue_plane[fill_idx] = b;
        fill_idx++;
        if (fill_idx == FrameBytes) begin
          fill_idx = 0;
          rx_phase = ModeWait;
          r.kind   = KindReply;
          r.data   = ChEnd;
        end
      end
      default: begin
        if (b == ChEnd) begin
          commit   = 1'b1;
          rx_phase = ModeIdle;
        end
      end
    endcase
    r.mode = rx_phase;
    if (commit) begin
      for (int i = 0; i < 2 * FrameBytes; i++) begin
        r.kind     = KindFrame;
        r.color    = (i >= FrameBytes);
        r.position = 5'(i % FrameBytes);
        r.data     = r.color ? blue_plane[i % FrameBytes] : red_plane[i];
        r.mode     = ModeIdle;
        r.last     = (i == 2 * FrameBytes - 1);
        batch.push_back(r);
      end
    end else begin
      batch.push_back(r);
    end
    if (typed) begin
      batch.delete();
      batch.push_back(typed_res);
    end
    foreach (batch[i]) owed_results.push_back(batch[i]);
    owed_total += batch.size();
  endtask

  // offer one request and hold it until accepted
  task automatic deliver(input logic [7:0] b, input bit typed, input frame_result_t res);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    track_rx_byte(b, typed, res);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (seen_total != owed_total) @(posedge clk_i);
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0:       return ChStart;
      1:       return ChEnd;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (in_valid && in_ready_o) taken <= taken + 1;
  end

  // result side: random stalls plus one long hold-off so the input backs up
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && taken >= HoldAt) begin
      out_ready  <= 1'b0;
      stall_left <= HoldCycles;
      stall_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      seen_total <= seen_total + 1;
      if (owed_results.size() == 0) begin
        $error("unexpected result: kind %0d data %0h", kind_o, data_o);
        err_count++;
      end else begin
        want = owed_results.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          err_count++;
        end
        if (data_o !== want.data) begin
          $error("data: expected %0h, got %0h", want.data, data_o);
          err_count++;
        end
        if (color_o !== want.color) begin
          $error("color: expected %0d, got %0d", want.color, color_o);
          err_count++;
        end
        if (position_o !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, position_o);
          err_count++;
        end
        if (mode_o !== want.mode) begin
          $error("mode: expected %0d, got %0d", want.mode, mode_o);
          err_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          err_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t     plan[16];
    frame_result_t none;
    logic [7:0]    b;
    int unsigned   rnd_count;

    none = single(KindStatus, 8'h00, ModeIdle);
    plan[0]  = '{8'h00,   8'h00, 1,  1'b1, single(KindStatus, 8'h00, ModeIdle)};
    plan[1]  = '{8'hFF,   8'h00, 1,  1'b1, single(KindStatus, 8'h00, ModeIdle)};
    plan[2]  = '{ChEnd,   8'h00, 1,  1'b1, single(KindStatus, 8'h00, ModeIdle)};
    plan[3]  = '{ChStart, 8'h00, 1,  1'b1, single(KindReply, ChStart, ModeRed)};
    // start and end characters inside a plane are plain data
    plan[4]  = '{8'hFF,   8'h00, 1,  1'b1, single(KindStatus, 8'h00, ModeRed)};
    plan[5]  = '{ChStart, 8'h00, 1,  1'b1, single(KindStatus, 8'h00, ModeRed)};
    plan[6]  = '{ChEnd,   8'h00, 1,  1'b1, single(KindStatus, 8'h00, ModeRed)};
    plan[7]  = '{8'h00,   8'h00, 1,  1'b1, single(KindStatus, 8'h00, ModeRed)};
    plan[8]  = '{8'h01,   8'h01, 15, 1'b0, none};
    plan[9]  = '{8'h80,   8'h11, 5,  1'b0, none};
    plan[10] = '{8'hFF,   8'hF5, 23, 1'b0, none};
    plan[11] = '{8'h7E,   8'h00, 1,  1'b1, single(KindReply, ChEnd, ModeWait)};
    plan[12] = '{8'h00,   8'h00, 1,  1'b1, single(KindStatus, 8'h00, ModeWait)};
    plan[13] = '{ChStart, 8'h00, 1,  1'b1, single(KindStatus, 8'h00, ModeWait)};
    plan[14] = '{8'hFF,   8'h00, 1,  1'b1, single(KindStatus, 8'h00, ModeWait)};
    plan[15] = '{ChEnd,   8'h00, 1,  1'b0, none};

    send_gap_pct = 34;
    recv_gap_pct <= 48;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].count; k++) begin
        deliver(8'(plan[r].first + k * plan[r].step), plan[r].typed, plan[r].res);
      end
    end
    drain_results();

    rnd_count = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = (ph == 0) ? 34 : (ph == 1) ? 48 : 0;
      recv_gap_pct <= (ph == 0) ? 48 : (ph == 1) ? 34 : 0;
      while (rnd_count < (ph + 1) * PhaseItems) begin
        if ($urandom_range(0, 9) < 7) begin
          // well-formed frame with random content
          deliver(ChStart, 1'b0, none);
          rnd_count++;
          repeat (2 * FrameBytes) begin
            b = ($urandom_range(0, 7) == 0) ? noise_byte() : 8'($urandom);
            deliver(b, 1'b0, none);
            rnd_count++;
          end
          repeat ($urandom_range(0, 3)) begin
            do b = noise_byte(); while (b == ChEnd);
            deliver(b, 1'b0, none);
            rnd_count++;
          end
          deliver(ChEnd, 1'b0, none);
          rnd_count++;
        end else begin
          repeat ($urandom_range(1, 6)) begin
            deliver(noise_byte(), 1'b0, none);
            rnd_count++;
          end
        end
      end
      drain_results();
    end

    repeat (16) @(posedge clk_i);
    if (err_count == 0 && owed_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
design/tcfr_pkg.sv
design/tcfr_queue.sv
design/tcfr_front.sv
design/tcfr_back.sv
design/two_color_frame_receiver.sv
test/testbench.sv
